// ===== sv/magnetic_heading_from_field_macros.svh =====
// Assertion macros for the magnetic heading block
`ifndef MAGNETIC_HEADING_FROM_FIELD_MACROS_SVH
`define MAGNETIC_HEADING_FROM_FIELD_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MHF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mhf_pkg.sv =====
// Shared widths, constants, types and the arctangent table for the heading block
`default_nettype none

package mhf_pkg;

  localparam int MAG_W            = 16;
  localparam int HEAD_W           = 16;
  localparam int DECL_W           = 16;
  localparam int FRAC_BITS        = 8;
  localparam int ANGLE_TABLE_LEN  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // vector lanes: samples x256, negated, plus CORDIC gain growth
  localparam int VEC_W  = 27;
  // angle accumulator, hundredths of a degree in Q8
  localparam int Z_W    = 25;
  localparam int ATAN_W = 21;
  // rounded angle and angle minus declination
  localparam int ANG_W  = 17;
  localparam int DIFF_W = 18;

  localparam int HALF_TURN    = 18000;
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN_Q8 = HALF_TURN * (1 << FRAC_BITS);
  localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

  typedef logic signed [MAG_W-1:0]  mag_t;
  typedef logic        [HEAD_W-1:0] head_t;
  typedef logic signed [DECL_W-1:0] decl_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // atan(2^-i) in hundredths of a degree, Q8, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q8(input int idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:       v = ATAN_W'(1152000);
      1:       v = ATAN_W'(680065);
      2:       v = ATAN_W'(359328);
      3:       v = ATAN_W'(182400);
      4:       v = ATAN_W'(91554);
      5:       v = ATAN_W'(45822);
      6:       v = ATAN_W'(22916);
      7:       v = ATAN_W'(11459);
      8:       v = ATAN_W'(5730);
      9:       v = ATAN_W'(2865);
      10:      v = ATAN_W'(1432);
      11:      v = ATAN_W'(716);
      12:      v = ATAN_W'(358);
      13:      v = ATAN_W'(179);
      14:      v = ATAN_W'(90);
      15:      v = ATAN_W'(45);
      16:      v = ATAN_W'(22);
      17:      v = ATAN_W'(11);
      18:      v = ATAN_W'(6);
      19:      v = ATAN_W'(3);
      20:      v = ATAN_W'(1);
      21:      v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mhf_in_if.sv =====
// Sample channel: valid/ready with the X and Y field values
`default_nettype none

interface mhf_in_if import mhf_pkg::*;;
  logic valid;
  logic ready;
  mag_t mag_x;
  mag_t mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

`default_nettype wire

// ===== sv/mhf_out_if.sv =====
// Result channel: valid/ready with the heading
`default_nettype none

interface mhf_out_if import mhf_pkg::*;;
  logic  valid;
  logic  ready;
  head_t heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ===== sv/mhf_cfg_if.sv =====
// Configuration write channel: valid/ready with the declination value
`default_nettype none

interface mhf_cfg_if import mhf_pkg::*;;
  logic  valid;
  logic  ready;
  decl_t declination;

  modport source (output valid, output declination, input ready);
  modport sink   (input valid, input declination, output ready);
endinterface

`default_nettype wire

// ===== sv/magnetic_heading_from_field.sv =====
// Top level: pipelined CORDIC compass heading with declination correction
`default_nettype none
`include "magnetic_heading_from_field_macros.svh"

// Compass heading from one X/Y magnetometer sample per transfer. The angle
// atan2(mag_x, mag_y) is found by an unrolled CORDIC with one register stage
// per micro-rotation; a sample with mag_y of zero gives 180.00 degrees when
// mag_x is negative and 0 otherwise. The declination register is subtracted
// and the result wrapped into 0..35999 hundredths of a degree. One sample is
// taken every cycle while the skid register is empty; each passes an input
// stage, one stage per rotation, a rounding/subtract stage and a wrap stage.
// A one-entry skid register on the result side lets the pipeline keep taking
// samples in the cycle a result is held up; in_ch.ready is low only while it
// is full. The user writes declination through cfg_ch only while the block
// holds no work (the block does not enforce it); reset value zero, any 16-bit value accepted.
module magnetic_heading_from_field import mhf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mhf_in_if.sink    in_ch,
  mhf_out_if.source out_ch,
  mhf_cfg_if.sink   cfg_ch
);

  localparam int STEPS = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;

  // declination register
  decl_t decl_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else if (cfg_ch.valid) begin
      decl_r <= cfg_ch.declination;
    end
  end

  // pipeline advances whenever the skid register is free
  logic skid_full_r;
  logic adv;

  assign adv         = !skid_full_r;
  assign in_ch.ready = adv;

  // input stage: scale by 256, fold the left half-plane onto the right
  vec_t x_s, y_s, re0, im0;
  z_t   z0;
  logic y_neg, x_neg;

  always_comb begin
    x_s   = vec_t'(in_ch.mag_x) <<< FRAC_BITS;
    y_s   = vec_t'(in_ch.mag_y) <<< FRAC_BITS;
    y_neg = in_ch.mag_y[MAG_W-1];
    x_neg = in_ch.mag_x[MAG_W-1];
    re0   = y_neg ? -y_s : y_s;
    im0   = y_neg ? -x_s : x_s;
    if (!y_neg) begin
      z0 = '0;
    end else if (x_neg) begin
      z0 = -z_t'(HALF_TURN_Q8);
    end else begin
      z0 = z_t'(HALF_TURN_Q8);
    end
  end

  vec_t re_r   [0:STEPS];
  vec_t im_r   [0:STEPS];
  z_t   z_r    [0:STEPS];
  logic vld_r  [0:STEPS];
  logic spec_r [0:STEPS];
  logic xneg_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      re_r[0]   <= re0;
      im_r[0]   <= im0;
      z_r[0]    <= z0;
      spec_r[0] <= (in_ch.mag_y == '0);
      xneg_r[0] <= x_neg;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    vec_t dre, dim;
    z_t   da;
    logic rot_pos;

    always_comb begin
      dre     = im_r[i] >>> i;
      dim     = re_r[i] >>> i;
      da      = z_t'(atan_q8(i));
      rot_pos = (im_r[i] > 0);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rot_pos) begin
          re_r[i+1] <= re_r[i] + dre;
          im_r[i+1] <= im_r[i] - dim;
          z_r[i+1]  <= z_r[i] + da;
        end else begin
          re_r[i+1] <= re_r[i] - dre;
          im_r[i+1] <= im_r[i] + dim;
          z_r[i+1]  <= z_r[i] - da;
        end
        spec_r[i+1] <= spec_r[i];
        xneg_r[i+1] <= xneg_r[i];
      end
    end
  end

  // round to hundredths, pick the axis case, subtract declination
  z_t    z_rnd;
  ang_t  ang;
  diff_t diff_nxt;
  diff_t diff_r;
  logic  vld_a_r;

  always_comb begin
    z_rnd = z_r[STEPS] + z_t'(ROUND_HALF);
    if (spec_r[STEPS]) begin
      ang = xneg_r[STEPS] ? ang_t'(HALF_TURN) : '0;
    end else begin
      ang = ang_t'(z_rnd >>> FRAC_BITS);
    end
    diff_nxt = diff_t'(ang) - diff_t'(decl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
    end
  end

  // modulo-360 wrap; the difference lies within two turns either side
  diff_t wrap;
  head_t head_nxt;
  head_t head_r;
  logic  vld_b_r;

  always_comb begin
    if (diff_r < -diff_t'(FULL_TURN)) begin
      wrap = diff_r + diff_t'(2 * FULL_TURN);
    end else if (diff_r < 0) begin
      wrap = diff_r + diff_t'(FULL_TURN);
    end else if (diff_r >= diff_t'(FULL_TURN)) begin
      wrap = diff_r - diff_t'(FULL_TURN);
    end else begin
      wrap = diff_r;
    end
    head_nxt = wrap[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_r <= head_nxt;
    end
  end

  // skid register: catches the last stage when the result is not taken
  head_t skid_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_ch.ready) begin
        skid_full_r <= 1'b0;
      end
    end else if (vld_b_r && !out_ch.ready) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_head_r <= head_r;
    end
  end

  assign out_ch.valid   = skid_full_r || vld_b_r;
  assign out_ch.heading = skid_full_r ? skid_head_r : head_r;

  // checks
  `MHF_ASSERT_NOW(a_heading_range, out_ch.valid, out_ch.heading < head_t'(FULL_TURN), "heading out of range")
  `MHF_ASSERT_NEXT(a_skid_catch, vld_b_r && !skid_full_r && !out_ch.ready, skid_full_r && (skid_head_r == $past(head_r)), "stalled result not held in skid register")
  `MHF_ASSERT_NEXT(a_skid_hold, skid_full_r && !out_ch.ready, skid_full_r && $stable(skid_head_r) && $stable(head_r), "skid register or pipeline moved while stalled")

endmodule

`default_nettype wire
